// ----- design/cfl_pkg.sv -----
// Shared types and constants of the circular free-list page allocator.
`timescale 1ns / 1ps

package cfl_pkg;

    // Page store geometry
    localparam int MAX_PAGES = 1024;
    localparam int ID_W      = 10;
    localparam int CNT_W     = 11;
    localparam int OP_W      = 2;
    localparam int ST_W      = 2;

    // Opcodes of an input word
    localparam logic [OP_W-1:0] OP_FETCH = 2'd0;
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd1;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd2;

    // Status codes of a result word
    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_UNUSED = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL   = 2'd2;
    localparam logic [ST_W-1:0] ST_RANGE  = 2'd3;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_RD1,
        S_RD2,
        S_WR2,
        S_DONE
    } t_state;

    // Access request from the sequencer to the page store
    typedef struct packed {
        logic            nf_re;
        logic [ID_W-1:0] nf_raddr;
        logic            nf_we;
        logic [ID_W-1:0] nf_waddr;
        logic [ID_W-1:0] nf_wdata;
        logic            iu_re;
        logic [ID_W-1:0] iu_raddr;
        logic            iu_we;
        logic [ID_W-1:0] iu_waddr;
        logic            iu_wdata;
    } t_mem_req;

    // Read data returned by the page store
    typedef struct packed {
        logic [ID_W-1:0] nf_rdata;
        logic            iu_rdata;
    } t_mem_rsp;

    // One result word
    typedef struct packed {
        logic [CNT_W-1:0] pages_in_file;
        logic [ST_W-1:0]  status;
        logic [ID_W-1:0]  result_page;
    } t_result;

endpackage

// ----- design/cfl_store.sv -----
// Page store: next-pointer memory and used-mark memory, both with registered reads.
`timescale 1ns / 1ps

module cfl_store
    import cfl_pkg::*;
(
    input  logic     i_clk,
    input  t_mem_req i_req,
    output t_mem_rsp o_rsp
);

    logic [ID_W-1:0] r_next_free [MAX_PAGES];
    logic            r_in_use    [MAX_PAGES];
    logic [ID_W-1:0] r_nf_rdata;
    logic            r_iu_rdata;

    // Next-pointer memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (i_req.nf_we) begin
            r_next_free[i_req.nf_waddr] <= i_req.nf_wdata;
        end
        if (i_req.nf_re) begin
            r_nf_rdata <= r_next_free[i_req.nf_raddr];
        end
    end

    // Used-mark memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (i_req.iu_we) begin
            r_in_use[i_req.iu_waddr] <= i_req.iu_wdata;
        end
        if (i_req.iu_re) begin
            r_iu_rdata <= r_in_use[i_req.iu_raddr];
        end
    end

    assign o_rsp.nf_rdata = r_nf_rdata;
    assign o_rsp.iu_rdata = r_iu_rdata;

endmodule

// ----- design/cfl_ctrl.sv -----
// Sequencer: read-modify-write of the free list and used marks for one word at a time.
`timescale 1ns / 1ps

module cfl_ctrl
    import cfl_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic [OP_W-1:0] i_opcode,
    input  logic [ID_W-1:0] i_page_id,
    input  logic            i_out_free,
    output logic            o_res_valid,
    output t_result         o_res,
    output t_mem_req        o_req,
    input  t_mem_rsp        i_rsp
);

    t_state           r_state, n_state;
    logic [OP_W-1:0]  r_op, n_op;
    logic [ID_W-1:0]  r_id, n_id;
    logic [CNT_W-1:0] r_count, n_count;
    logic [ID_W-1:0]  r_tail, n_tail;
    logic             r_empty, n_empty;
    logic [ID_W-1:0]  r_res_page, n_res_page;
    logic [ST_W-1:0]  r_res_status, n_res_status;
    logic             w_accept;
    logic             w_range;
    logic [ID_W-1:0]  w_head;

    assign w_head  = i_rsp.nf_rdata;
    assign w_range = ({1'b0, r_id} >= r_count);

    // State and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_tail  <= '0;
            r_empty <= 1'b1;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_tail  <= n_tail;
            r_empty <= n_empty;
        end
    end

    // Word and result holding registers
    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_id         <= n_id;
        r_res_page   <= n_res_page;
        r_res_status <= n_res_status;
    end

    // Next state, memory accesses and result
    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_id         = r_id;
        n_count      = r_count;
        n_tail       = r_tail;
        n_empty      = r_empty;
        n_res_page   = r_res_page;
        n_res_status = r_res_status;
        o_req        = '0;
        o_res_valid  = 1'b0;
        o_in_ready   = i_rst_n &&
                       ((r_state == S_IDLE) || ((r_state == S_DONE) && i_out_free));
        w_accept     = i_in_valid && o_in_ready;

        case (r_state)
            S_RD1: begin
                n_res_page   = r_id;
                n_res_status = ST_OK;
                n_state      = S_DONE;
                case (r_op)
                    OP_ALLOC: begin
                        if (r_empty) begin
                            if (r_count >= CNT_W'(MAX_PAGES)) begin
                                n_res_page   = '0;
                                n_res_status = ST_FULL;
                            end else begin
                                // Create a fresh page at the end of the file
                                o_req.iu_we    = 1'b1;
                                o_req.iu_waddr = r_count[ID_W-1:0];
                                o_req.iu_wdata = 1'b1;
                                n_res_page     = r_count[ID_W-1:0];
                                n_count        = r_count + CNT_W'(1);
                            end
                        end else begin
                            // Take the head, the page after the tail
                            o_req.iu_we    = 1'b1;
                            o_req.iu_waddr = w_head;
                            o_req.iu_wdata = 1'b1;
                            n_res_page     = w_head;
                            n_id           = w_head;
                            if (w_head == r_tail) begin
                                n_empty = 1'b1;
                            end else begin
                                o_req.nf_re    = 1'b1;
                                o_req.nf_raddr = w_head;
                                n_state        = S_RD2;
                            end
                        end
                    end
                    OP_FREE: begin
                        if (w_range) begin
                            n_res_status = ST_RANGE;
                        end else if (!i_rsp.iu_rdata) begin
                            n_res_status = ST_UNUSED;
                        end else begin
                            o_req.iu_we    = 1'b1;
                            o_req.iu_waddr = r_id;
                            o_req.iu_wdata = 1'b0;
                            o_req.nf_we    = 1'b1;
                            o_req.nf_waddr = r_id;
                            if (r_empty) begin
                                // Single free page points to itself
                                o_req.nf_wdata = r_id;
                                n_tail         = r_id;
                                n_empty        = 1'b0;
                            end else begin
                                // Freed page points to the old head
                                o_req.nf_wdata = w_head;
                                n_state        = S_WR2;
                            end
                        end
                    end
                    default: begin
                        if (w_range) begin
                            n_res_status = ST_RANGE;
                        end else if (!i_rsp.iu_rdata) begin
                            n_res_status = ST_UNUSED;
                        end
                    end
                endcase
            end
            S_RD2: begin
                // Unlink the taken head: tail now points past it
                o_req.nf_we    = 1'b1;
                o_req.nf_waddr = r_tail;
                o_req.nf_wdata = w_head;
                n_state        = S_DONE;
            end
            S_WR2: begin
                // Link the freed page after the tail and make it the tail
                o_req.nf_we    = 1'b1;
                o_req.nf_waddr = r_tail;
                o_req.nf_wdata = r_id;
                n_tail         = r_id;
                n_state        = S_DONE;
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_res_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Take a new word and start its reads
        if (w_accept) begin
            n_op           = i_opcode;
            n_id           = i_page_id;
            n_state        = S_RD1;
            o_req.nf_re    = 1'b1;
            o_req.nf_raddr = r_tail;
            o_req.iu_re    = 1'b1;
            o_req.iu_raddr = i_page_id;
        end
    end

    assign o_res.result_page   = r_res_page;
    assign o_res.status        = r_res_status;
    assign o_res.pages_in_file = r_count;

endmodule

// ----- design/circular_free_list_page_allocator_top.sv -----
// Top level of the circular free-list page allocator with its output register.
`timescale 1ns / 1ps

// Page allocator keeping freed pages in a circular linked list whose tail is
// held in a register; the head is the page after the tail. Every input word
// (fetch check, allocate, free) gives exactly one result word. Words are
// handled one at a time: fetch checks, refused requests, an allocate that
// empties the list or creates a page and a free into an empty list go from
// S_RD1 to S_DONE; a free into a non-empty list adds S_WR2 for its second link
// write, and an allocate from a list of two or more pages adds S_RD2, set by
// the two dependent reads of the synchronous next-pointer memory (tail, then
// head) followed by the write back. A result waiting in the output register
// does not stop the next word from being taken, but a second finished result
// holds the block until the first one is taken. The used marks need no clearing
// pass after reset: only marks of pages below the page count are used, each
// written when it is created, so the block is ready straight out of reset.

module circular_free_list_page_allocator_top
    import cfl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [1:0] opcode, [11:2] page_id, [15:12] zero
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata    // [9:0] result_page, [11:10] status,
                                     // [22:12] pages_in_file, [23] zero
);

    t_mem_req w_req;
    t_mem_rsp w_rsp;
    t_result  w_res;
    logic     w_res_valid;
    logic     w_out_free;
    logic     r_out_valid;
    t_result  r_out;

    assign w_out_free = !r_out_valid || i_m_tready;

    cfl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .o_in_ready  (o_s_tready),
        .i_opcode    (i_s_tdata[OP_W-1:0]),
        .i_page_id   (i_s_tdata[OP_W+ID_W-1:OP_W]),
        .i_out_free  (w_out_free),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .o_req       (w_req),
        .i_rsp       (w_rsp)
    );

    cfl_store u_store (
        .i_clk (i_clk),
        .i_req (w_req),
        .o_rsp (w_rsp)
    );

    // Output register: load a finished result, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out};

endmodule
